/* src/index_pulse_angle_estimator_assert.svh */
// assertion macros for the index pulse angle estimator
`ifndef INDEX_PULSE_ANGLE_ESTIMATOR_ASSERT_SVH
`define INDEX_PULSE_ANGLE_ESTIMATOR_ASSERT_SVH

// same-cycle implication
`define IPAE_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ipae assertion failed");

// next-cycle implication
`define IPAE_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ipae assertion failed");

`endif

/* src/ipae_pkg.sv */
// types, codes and constants of the index pulse angle estimator
`default_nettype none
package ipae_pkg;

  localparam int TIME_BITS_DEF  = 32;
  localparam int COUNT_BITS_DEF = 16;

  localparam int CMD_BITS        = 3;
  localparam int KIND_BITS       = 3;
  localparam int FIELD_TIME_BITS = 32;
  localparam int CFG_BITS        = 32;
  localparam int CFG_IDX_BITS    = 2;
  localparam int ANGLE_BITS      = 9;
  localparam int PERIOD_MS_BITS  = 23;
  localparam int EDGE_CNT_BITS   = 16;
  localparam int SCALE_IDX_BITS  = 4;

  localparam logic [ANGLE_BITS-1:0] DEG_PER_REV = 9'd360;
  localparam int                    US_PER_MS   = 1000;

  localparam logic [CFG_BITS-1:0] STREAM_INTERVAL_RST = 32'd20;
  localparam logic [CFG_BITS-1:0] MIN_PERIOD_RST      = 32'd1000000;
  localparam logic [CFG_BITS-1:0] MAX_PERIOD_RST      = 32'd60000000;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_EDGE       = 3'd0,
    CMD_QUERY      = 3'd1,
    CMD_STREAM_ON  = 3'd2,
    CMD_STREAM_OFF = 3'd3,
    CMD_RESET      = 3'd4,
    CMD_TICK       = 3'd5,
    CMD_UNKNOWN    = 3'd6
  } cmd_e;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_POS       = 3'd0,
    KIND_NA        = 3'd1,
    KIND_ON_ACK    = 3'd2,
    KIND_OFF_ACK   = 3'd3,
    KIND_RESET_ACK = 3'd4,
    KIND_UNKNOWN   = 3'd5
  } kind_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_STREAM_INTERVAL = 2'd0,
    REG_MIN_PERIOD      = 2'd1,
    REG_MAX_PERIOD      = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [CMD_BITS-1:0]        command;
    logic [FIELD_TIME_BITS-1:0] time_us;
    logic [FIELD_TIME_BITS-1:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic [KIND_BITS-1:0]      report_kind;
    logic [ANGLE_BITS-1:0]     angle_deg;
    logic [PERIOD_MS_BITS-1:0] period_ms;
    logic [EDGE_CNT_BITS-1:0]  edge_count;
  } out_item_t;

  typedef struct packed {
    logic  capture;
    logic  edge_upd;
    logic  stream_on;
    logic  stream_off;
    logic  clear;
    logic  stream_mark;
    logic  div_start;
    logic  ms_start;
    logic  scale_init;
    logic  scale_dbl;
    logic  scale_add;
    logic  out_load;
    kind_e kind;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_BITS-1:0] command;
    logic                pos_na;
    logic                tick_due;
    logic                div_busy;
    logic                ms_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

/* src/ipae_div.sv */
// restoring divider, one quotient bit per cycle
`default_nettype none
module ipae_div #(
  parameter int TIME_BITS = ipae_pkg::TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [TIME_BITS-1:0] dividend_i,
  input  logic [TIME_BITS-1:0] divisor_i,
  output logic                 busy_o,
  output logic [TIME_BITS-1:0] remainder_o
);
  localparam int CNT_BITS = $clog2(TIME_BITS);

  logic                 busy_q;
  logic [CNT_BITS-1:0]  cnt_q;
  logic [TIME_BITS-1:0] dvd_q;
  logic [TIME_BITS-1:0] dvs_q;
  logic [TIME_BITS-1:0] rem_q;
  logic [TIME_BITS:0]   rem_sh;
  logic [TIME_BITS:0]   diff;

  assign rem_sh = {rem_q, dvd_q[TIME_BITS-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_BITS'(TIME_BITS - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (!diff[TIME_BITS]) begin
        rem_q <= diff[TIME_BITS-1:0];
        dvd_q <= {dvd_q[TIME_BITS-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[TIME_BITS-1:0];
        dvd_q <= {dvd_q[TIME_BITS-2:0], 1'b0};
      end
    end
  end

  assign busy_o      = busy_q;
  assign remainder_o = rem_q;
endmodule
`default_nettype wire

/* src/ipae_datapath.sv */
// configuration, revolution state, divider, angle scaler, ms multiplier and result register
`default_nettype none
module ipae_datapath #(
  parameter int TIME_BITS  = ipae_pkg::TIME_BITS_DEF,
  parameter int COUNT_BITS = ipae_pkg::COUNT_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [ipae_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [ipae_pkg::CFG_BITS-1:0]         cfg_data_i,
  input  ipae_pkg::in_item_t                    in_item_i,
  input  ipae_pkg::dp_cmd_t                     cmd_i,
  output ipae_pkg::dp_stat_t                    stat_o,
  output ipae_pkg::out_item_t                   out_item_o
);
  import ipae_pkg::*;

  localparam int CMP_BITS = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

  // period in ms by reciprocal multiply, one 16-bit limb of the period per cycle
  localparam int MS_LIMB     = 16;
  localparam int MS_LIMBS    = (TIME_BITS + MS_LIMB - 1) / MS_LIMB;
  localparam int MS_PW       = MS_LIMBS * MS_LIMB;
  localparam int MS_SHIFT    = TIME_BITS + $clog2(US_PER_MS);
  localparam int MS_SW       = MS_SHIFT + 1;
  localparam int MS_MW       = TIME_BITS + 1;
  localparam int MS_PRW      = MS_LIMB + MS_MW;
  localparam int MS_AW       = MS_PW + MS_MW;
  localparam int MS_CNT_BITS = $clog2(MS_LIMBS + 1);
  localparam logic [MS_SW-1:0] MS_POW     = MS_SW'(1) << MS_SHIFT;
  localparam logic [MS_SW-1:0] MS_RECIP_W = (MS_POW + MS_SW'(US_PER_MS - 1)) /
                                            MS_SW'(US_PER_MS);
  localparam logic [MS_MW-1:0] MS_RECIP   = MS_RECIP_W[MS_MW-1:0];

  logic [CFG_BITS-1:0]   interval_q, min_period_q, max_period_q;
  logic [TIME_BITS-1:0]  last_edge_q, period_q, last_stream_q;
  logic                  edge_seen_q, streaming_q;
  logic [COUNT_BITS-1:0] edges_q;

  logic [CMD_BITS-1:0]   cmd_q;
  logic [TIME_BITS-1:0]  tus_q, tms_q;
  logic [TIME_BITS-1:0]  e_q, sc_r_q;
  logic [ANGLE_BITS-1:0] sc_q_q;
  out_item_t             out_q;

  logic [MS_PW-1:0]       ms_p_q;
  logic [MS_AW-1:0]       ms_acc_q;
  logic [MS_CNT_BITS-1:0] ms_cnt_q;
  logic [MS_PRW-1:0]      ms_prod;
  logic                   ms_busy;

  logic [TIME_BITS-1:0]  elapsed, stream_gap, pmr, pme;
  logic                  edge_ok;
  logic                  div_busy;
  logic [TIME_BITS-1:0]  div_dvd, div_dvs, div_rem;

  assign elapsed    = tus_q - last_edge_q;
  assign stream_gap = tms_q - last_stream_q;
  assign edge_ok    = (CMP_BITS'(elapsed) > CMP_BITS'(min_period_q)) &&
                      (CMP_BITS'(elapsed) < CMP_BITS'(max_period_q));
  assign pmr        = period_q - sc_r_q;
  assign pme        = period_q - e_q;

  assign div_dvd = elapsed;
  assign div_dvs = period_q;

  ipae_div #(
    .TIME_BITS(TIME_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .remainder_o(div_rem)
  );

  assign ms_prod = {{MS_MW{1'b0}}, ms_p_q[MS_PW-1 -: MS_LIMB]} *
                   {{MS_LIMB{1'b0}}, MS_RECIP};
  assign ms_busy = (ms_cnt_q != '0);

  assign stat_o.command  = cmd_q;
  assign stat_o.pos_na   = (period_q == '0) || !edge_seen_q || (tus_q < last_edge_q);
  assign stat_o.tick_due = streaming_q &&
                           (CMP_BITS'(stream_gap) >= CMP_BITS'(interval_q));
  assign stat_o.div_busy = div_busy;
  assign stat_o.ms_busy  = ms_busy;

  // configuration and revolution state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q    <= STREAM_INTERVAL_RST;
      min_period_q  <= MIN_PERIOD_RST;
      max_period_q  <= MAX_PERIOD_RST;
      last_edge_q   <= '0;
      edge_seen_q   <= 1'b0;
      period_q      <= '0;
      edges_q       <= '0;
      streaming_q   <= 1'b0;
      last_stream_q <= '0;
      ms_cnt_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_STREAM_INTERVAL: interval_q   <= cfg_data_i;
          REG_MIN_PERIOD:      min_period_q <= cfg_data_i;
          REG_MAX_PERIOD:      max_period_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.edge_upd) begin
        if (!edge_seen_q) begin
          last_edge_q <= tus_q;
          edge_seen_q <= 1'b1;
        end else if (edge_ok) begin
          edges_q     <= edges_q + 1'b1;
          period_q    <= elapsed;
          last_edge_q <= tus_q;
        end
      end
      if (cmd_i.clear) begin
        last_edge_q <= '0;
        edge_seen_q <= 1'b0;
        period_q    <= '0;
        edges_q     <= '0;
      end
      if (cmd_i.stream_on) begin
        streaming_q <= 1'b1;
      end
      if (cmd_i.stream_off) begin
        streaming_q <= 1'b0;
      end
      if (cmd_i.stream_mark) begin
        last_stream_q <= tms_q;
      end
      if (cmd_i.ms_start) begin
        ms_cnt_q <= MS_CNT_BITS'(MS_LIMBS);
      end else if (ms_busy) begin
        ms_cnt_q <= ms_cnt_q - 1'b1;
      end
    end
  end

  // transaction capture, angle scaler, ms multiplier, result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q <= in_item_i.command;
      tus_q <= TIME_BITS'(in_item_i.time_us);
      tms_q <= TIME_BITS'(in_item_i.time_ms);
    end
    if (cmd_i.scale_init) begin
      e_q    <= div_rem;
      sc_r_q <= '0;
      sc_q_q <= '0;
    end else if (cmd_i.scale_dbl) begin
      if (sc_r_q >= pmr) begin
        sc_r_q <= sc_r_q - pmr;
        sc_q_q <= {sc_q_q[ANGLE_BITS-2:0], 1'b1};
      end else begin
        sc_r_q <= {sc_r_q[TIME_BITS-2:0], 1'b0};
        sc_q_q <= {sc_q_q[ANGLE_BITS-2:0], 1'b0};
      end
    end else if (cmd_i.scale_add) begin
      if (sc_r_q >= pme) begin
        sc_r_q <= sc_r_q - pme;
        sc_q_q <= sc_q_q + 1'b1;
      end else begin
        sc_r_q <= sc_r_q + e_q;
      end
    end
    if (cmd_i.ms_start) begin
      ms_p_q   <= MS_PW'(period_q);
      ms_acc_q <= '0;
    end else if (ms_busy) begin
      ms_p_q   <= ms_p_q << MS_LIMB;
      ms_acc_q <= (ms_acc_q << MS_LIMB) + MS_AW'(ms_prod);
    end
    if (cmd_i.out_load) begin
      out_q.report_kind <= cmd_i.kind;
      if (cmd_i.kind == KIND_POS) begin
        out_q.angle_deg  <= sc_q_q;
        out_q.period_ms  <= PERIOD_MS_BITS'(ms_acc_q >> MS_SHIFT);
        out_q.edge_count <= EDGE_CNT_BITS'(edges_q);
      end else begin
        out_q.angle_deg  <= '0;
        out_q.period_ms  <= '0;
        out_q.edge_count <= '0;
      end
    end
  end

  assign out_item_o = out_q;
endmodule
`default_nettype wire

/* src/ipae_ctrl.sv */
// command sequencer and result handshake
`default_nettype none
module ipae_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  ipae_pkg::dp_stat_t stat_i,
  output ipae_pkg::dp_cmd_t  cmd_o
);
  import ipae_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MOD_WAIT,
    ST_SCALE_DBL,
    ST_SCALE_ADD,
    ST_MS_WAIT,
    ST_EMIT
  } state_e;

  state_e                    state_q, state_d;
  kind_e                     kind_q, kind_d;
  logic [SCALE_IDX_BITS-1:0] bit_q, bit_d;
  logic                      out_valid_q, out_valid_d;
  logic                      slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    bit_d       = bit_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.kind  = kind_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (stat_i.command)
          CMD_EDGE: begin
            cmd_o.edge_upd = 1'b1;
            state_d        = ST_IDLE;
          end
          CMD_QUERY, CMD_TICK: begin
            if (stat_i.command == CMD_TICK && !stat_i.tick_due) begin
              state_d = ST_IDLE;
            end else begin
              cmd_o.stream_mark = (stat_i.command == CMD_TICK);
              if (stat_i.pos_na) begin
                kind_d  = KIND_NA;
                state_d = ST_EMIT;
              end else begin
                cmd_o.div_start = 1'b1;
                cmd_o.ms_start  = 1'b1;
                state_d         = ST_MOD_WAIT;
              end
            end
          end
          CMD_STREAM_ON: begin
            cmd_o.stream_on = 1'b1;
            kind_d          = KIND_ON_ACK;
            state_d         = ST_EMIT;
          end
          CMD_STREAM_OFF: begin
            cmd_o.stream_off = 1'b1;
            kind_d           = KIND_OFF_ACK;
            state_d          = ST_EMIT;
          end
          CMD_RESET: begin
            cmd_o.clear = 1'b1;
            kind_d      = KIND_RESET_ACK;
            state_d     = ST_EMIT;
          end
          default: begin
            kind_d  = KIND_UNKNOWN;
            state_d = ST_EMIT;
          end
        endcase
      end
      ST_MOD_WAIT: begin
        if (!stat_i.div_busy) begin
          cmd_o.scale_init = 1'b1;
          bit_d            = SCALE_IDX_BITS'(ANGLE_BITS - 1);
          state_d          = ST_SCALE_DBL;
        end
      end
      ST_SCALE_DBL: begin
        cmd_o.scale_dbl = 1'b1;
        if (DEG_PER_REV[bit_q]) begin
          state_d = ST_SCALE_ADD;
        end else if (bit_q == '0) begin
          state_d = ST_MS_WAIT;
        end else begin
          bit_d = bit_q - 1'b1;
        end
      end
      ST_SCALE_ADD: begin
        cmd_o.scale_add = 1'b1;
        if (bit_q == '0) begin
          state_d = ST_MS_WAIT;
        end else begin
          bit_d   = bit_q - 1'b1;
          state_d = ST_SCALE_DBL;
        end
      end
      ST_MS_WAIT: begin
        if (!stat_i.ms_busy) begin
          kind_d  = KIND_POS;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= KIND_POS;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
endmodule
`default_nettype wire

/* src/index_pulse_angle_estimator.sv */
// Index pulse angle estimator. Takes one timestamped event per transaction and
// keeps the revolution period from index edges whose spacing falls strictly
// inside the min/max window. Edges and ticks that are not due give no result;
// stream on/off, reset, unknown commands and reports that answer not available
// give a result without the divider or scaler. For a position report (query,
// or a due tick while streaming) a one-bit-per-cycle divider forms the elapsed
// time modulo the period, then bit-serial scaling by 360 gives the angle, while
// the period in ms comes from a reciprocal multiply that finishes during the
// divide. One transaction is in work at a time; a finished result waits in the
// output register while the next transaction is taken in, and the result stage
// waits as long as that register is still held by the receiver.
`default_nettype none
module index_pulse_angle_estimator #(
  parameter int TIME_BITS  = ipae_pkg::TIME_BITS_DEF,
  parameter int COUNT_BITS = ipae_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ipae_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [ipae_pkg::CFG_BITS-1:0]     cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  ipae_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output ipae_pkg::out_item_t               out_item_o
);
  import ipae_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  ipae_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  ipae_datapath #(
    .TIME_BITS (TIME_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_item_i  (in_item_i),
    .cmd_i      (dp_cmd),
    .stat_o     (dp_stat),
    .out_item_o (out_item_o)
  );
endmodule
`default_nettype wire

/* src/ipae_checker.sv */
// port-level checks of the index pulse angle estimator and their binding
`default_nettype none
`include "index_pulse_angle_estimator_assert.svh"
module ipae_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input ipae_pkg::out_item_t out_item_i
);
  import ipae_pkg::*;

  `IPAE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_item_i))
  `IPAE_ASSERT_IMP(a_kind_range, clk_i, rst_ni, out_valid_i, out_item_i.report_kind <= KIND_UNKNOWN)
  `IPAE_ASSERT_IMP(a_fields_zero, clk_i, rst_ni, out_valid_i && out_item_i.report_kind != KIND_POS, out_item_i.angle_deg == '0 && out_item_i.period_ms == '0 && out_item_i.edge_count == '0)
  `IPAE_ASSERT_IMP(a_angle_range, clk_i, rst_ni, out_valid_i && out_item_i.report_kind == KIND_POS, out_item_i.angle_deg < DEG_PER_REV)
  `IPAE_ASSERT_NXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)
endmodule

bind index_pulse_angle_estimator ipae_checker u_ipae_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_i (in_ready_o),
  .out_valid_i(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_item_i (out_item_o)
);
`default_nettype wire

/* verif/index_pulse_angle_estimator_checker.sv */
// checker for the index pulse angle estimator: watches both channels, predicts and compares
`timescale 1ns / 100ps
module index_pulse_angle_estimator_checker
  import ipae_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [CFG_BITS-1:0]     cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  in_item_t                in_item_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  out_item_t               out_item_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  logic [CFG_BITS-1:0]        stream_interval_q;
  logic [CFG_BITS-1:0]        min_period_q;
  logic [CFG_BITS-1:0]        max_period_q;
  logic [FIELD_TIME_BITS-1:0] last_edge_q;
  logic                       edge_seen_q;
  logic [FIELD_TIME_BITS-1:0] period_q;
  logic [EDGE_CNT_BITS-1:0]   edge_count_q;
  logic                       streaming_q;
  logic [FIELD_TIME_BITS-1:0] last_stream_q;

  out_item_t report_q[$];

  function automatic out_item_t angle_report(input logic [FIELD_TIME_BITS-1:0] now);
    out_item_t                  rpt;
    logic [FIELD_TIME_BITS-1:0] phase;
    logic [63:0]                scaled;
    rpt = '0;
    if (period_q == '0 || !edge_seen_q || now < last_edge_q) begin
      rpt.report_kind = KIND_NA;
    end else begin
      phase           = (now - last_edge_q) % period_q;
      scaled          = {32'd0, phase} * {55'd0, DEG_PER_REV};
      rpt.report_kind = KIND_POS;
      rpt.angle_deg   = ANGLE_BITS'(scaled / {32'd0, period_q});
      rpt.period_ms   = PERIOD_MS_BITS'(period_q / US_PER_MS);
      rpt.edge_count  = edge_count_q;
    end
    return rpt;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      fail_count_o = fail_count_o + 1;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t                  rpt;
    logic                       has_rpt;
    logic [FIELD_TIME_BITS-1:0] gap;
    if (!rst_ni) begin
      stream_interval_q = STREAM_INTERVAL_RST;
      min_period_q      = MIN_PERIOD_RST;
      max_period_q      = MAX_PERIOD_RST;
      last_edge_q       = '0;
      edge_seen_q       = 1'b0;
      period_q          = '0;
      edge_count_q      = '0;
      streaming_q       = 1'b0;
      last_stream_q     = '0;
      report_q.delete();
      fail_count_o      = 0;
      pending_o         = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (report_q.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          $display("%0t: unexpected report, expected none, actual kind %0d", $time,
                   out_item_i.report_kind);
        end else begin
          rpt = report_q.pop_front();
          check_field("report_kind", rpt.report_kind, out_item_i.report_kind);
          check_field("angle_deg", rpt.angle_deg, out_item_i.angle_deg);
          check_field("period_ms", rpt.period_ms, out_item_i.period_ms);
          check_field("edge_count", rpt.edge_count, out_item_i.edge_count);
        end
      end

      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_STREAM_INTERVAL: stream_interval_q = cfg_data_i;
          REG_MIN_PERIOD:      min_period_q      = cfg_data_i;
          REG_MAX_PERIOD:      max_period_q      = cfg_data_i;
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        rpt     = '0;
        has_rpt = 1'b1;
        case (in_item_i.command)
          CMD_EDGE: begin
            has_rpt = 1'b0;
            if (!edge_seen_q) begin
              last_edge_q = in_item_i.time_us;
              edge_seen_q = 1'b1;
            end else begin
              gap = in_item_i.time_us - last_edge_q;
              if (gap > min_period_q && gap < max_period_q) begin
                edge_count_q = edge_count_q + 1'b1;
                period_q     = gap;
                last_edge_q  = in_item_i.time_us;
              end
            end
          end
          CMD_QUERY: rpt = angle_report(in_item_i.time_us);
          CMD_STREAM_ON: begin
            streaming_q     = 1'b1;
            rpt.report_kind = KIND_ON_ACK;
          end
          CMD_STREAM_OFF: begin
            streaming_q     = 1'b0;
            rpt.report_kind = KIND_OFF_ACK;
          end
          CMD_RESET: begin
            period_q        = '0;
            last_edge_q     = '0;
            edge_seen_q     = 1'b0;
            edge_count_q    = '0;
            rpt.report_kind = KIND_RESET_ACK;
          end
          CMD_TICK: begin
            has_rpt = 1'b0;
            if (streaming_q && (in_item_i.time_ms - last_stream_q) >= stream_interval_q) begin
              rpt           = angle_report(in_item_i.time_us);
              last_stream_q = in_item_i.time_ms;
              has_rpt       = 1'b1;
            end
          end
          default: rpt.report_kind = KIND_UNKNOWN;
        endcase
        if (has_rpt) report_q.push_back(rpt);
      end

      pending_o = report_q.size();
    end
  end

endmodule

/* verif/index_pulse_angle_estimator_tb.sv */
// testbench top for the index pulse angle estimator: stimulus, handshakes and verdict
`timescale 1ns / 100ps
module index_pulse_angle_estimator_tb;
  import ipae_pkg::*;

  localparam int CYCLE_LIMIT  = 1500000;
  localparam int DRAIN_CYCLES = 120;
  localparam int PHASE_ITEMS  = 315;
  localparam logic [CMD_BITS-1:0]     CMD_SPARE = 3'd7;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]     cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  in_item_t                in_item;
  logic                    out_valid;
  logic                    out_ready;
  out_item_t               out_item;
  int                      mismatches;
  int                      pending;

  int cycle_count = 0;
  int send_idle_pct;
  int recv_idle_pct;

  logic [31:0] g_si;
  logic [31:0] g_mn;
  logic [31:0] g_mx;
  logic [31:0] g_last_edge;
  logic [31:0] g_now;
  logic [31:0] g_ms;

  index_pulse_angle_estimator dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  index_pulse_angle_estimator_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_item_i  (out_item),
    .fail_count_o(mismatches),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL index_pulse_angle_estimator");
      $finish;
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_item(input logic [CMD_BITS-1:0] cmd, input logic [31:0] tus,
                           input logic [31:0] tms);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_item.command <= cmd;
    in_item.time_us <= tus;
    in_item.time_ms <= tms;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  task automatic apply_config(input logic [31:0] si, input logic [31:0] mn,
                              input logic [31:0] mx);
    write_reg(REG_STREAM_INTERVAL, si);
    write_reg(REG_MIN_PERIOD, mn);
    write_reg(REG_MAX_PERIOD, mx);
    write_reg(REG_SPARE, $urandom);
    cfg_we <= 1'b0;
    g_si = si;
    g_mn = mn;
    g_mx = mx;
  endtask

  // time near the last edge, sometimes just before it or anywhere
  function automatic logic [31:0] probe_time();
    logic [63:0] lim;
    lim = {32'd0, g_mx} * 64'd3 + 64'd1;
    case ($urandom_range(0, 7))
      0:       return $urandom;
      1:       return g_last_edge - 32'($urandom_range(1, 1000));
      default: return g_last_edge + 32'({32'd0, $urandom} % lim);
    endcase
  endfunction

  task automatic send_random();
    int          pick;
    logic [31:0] iv;
    logic [31:0] tus;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      case ($urandom_range(0, 9))
        0: iv = g_mn;
        1: iv = g_mn + 32'd1;
        2: iv = g_mx - 32'd1;
        3: iv = g_mx;
        4: iv = $urandom;
        default: begin
          if ({1'b0, g_mx} > {1'b0, g_mn} + 33'd1)
            iv = g_mn + 32'd1 + ($urandom % (g_mx - g_mn - 32'd1));
          else
            iv = $urandom;
        end
      endcase
      tus = g_last_edge + iv;
      if (iv > g_mn && iv < g_mx) g_last_edge = tus;
      g_now = tus;
      send_item(CMD_EDGE, tus, $urandom);
    end else if (pick < 60) begin
      send_item(CMD_QUERY, probe_time(), $urandom);
    end else if (pick < 80) begin
      if (g_si < 32'd100000) begin
        g_ms = g_ms + 32'($urandom_range(0, 2 * g_si + 2));
      end else begin
        case ($urandom_range(0, 2))
          0:       g_ms = g_ms + $urandom;
          1:       g_ms = g_ms + g_si;
          default: g_ms = g_ms + g_si - 32'd1;
        endcase
      end
      send_item(CMD_TICK, probe_time(), g_ms);
    end else if (pick < 86) begin
      send_item(CMD_STREAM_ON, $urandom, $urandom);
    end else if (pick < 90) begin
      send_item(CMD_STREAM_OFF, $urandom, $urandom);
    end else if (pick < 92) begin
      send_item(CMD_RESET, $urandom, $urandom);
    end else if (pick < 95) begin
      send_item($urandom_range(0, 1) ? CMD_UNKNOWN : CMD_SPARE, $urandom, $urandom);
    end else begin
      send_item(CMD_BITS'($urandom_range(0, 7)), $urandom, $urandom);
    end
  endtask

  initial begin
    logic [31:0] mn;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    in_item       <= '0;
    out_ready     <= 1'b0;
    send_idle_pct = 27;
    recv_idle_pct = 80;
    g_si = STREAM_INTERVAL_RST;
    g_mn = MIN_PERIOD_RST;
    g_mx = MAX_PERIOD_RST;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: no period, window edges, wrap, stream timing, unknown codes
    send_item(CMD_QUERY, 32'd0, 32'd0);
    send_item(CMD_TICK, 32'd100, 32'd50);
    send_item(CMD_STREAM_ON, 32'd0, 32'd0);
    send_item(CMD_TICK, 32'd0, 32'd19);
    send_item(CMD_TICK, 32'd0, 32'd20);
    send_item(CMD_EDGE, 32'd0, 32'd0);
    send_item(CMD_EDGE, 32'd1000000, 32'd0);
    send_item(CMD_EDGE, 32'd1000001, 32'd0);
    send_item(CMD_QUERY, 32'd1500001, 32'd0);
    send_item(CMD_QUERY, 32'd5, 32'd0);
    send_item(CMD_QUERY, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_item(CMD_EDGE, 32'd61000001, 32'd0);
    send_item(CMD_EDGE, 32'd61000000, 32'd0);
    send_item(CMD_QUERY, 32'd61000000, 32'd0);
    send_item(CMD_QUERY, 32'd120999998, 32'd0);
    send_item(CMD_TICK, 32'd61000100, 32'hFFFFFFFF);
    send_item(CMD_TICK, 32'd61000200, 32'hFFFFFFFF);
    send_item(CMD_STREAM_OFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_item(CMD_TICK, 32'd61000300, 32'd0);
    send_item(CMD_UNKNOWN, 32'd0, 32'd0);
    send_item(CMD_SPARE, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_item(CMD_RESET, 32'd0, 32'd0);
    send_item(CMD_QUERY, 32'd100, 32'd0);
    send_item(CMD_EDGE, 32'hFFFFFFFF, 32'd0);
    send_item(CMD_EDGE, 32'd2000000, 32'd0);
    send_item(CMD_QUERY, 32'hFFFFFFFF, 32'd0);
    wait_idle();

    g_last_edge = 32'd2000000;
    g_now       = 32'd2000000;
    g_ms        = 32'd0;

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: apply_config(STREAM_INTERVAL_RST, MIN_PERIOD_RST, MAX_PERIOD_RST);
        1: apply_config(32'd0, 32'd0, 32'hFFFFFFFF);
        2: apply_config(32'd5, 32'd100, 32'd5000);
        3: apply_config(32'hFFFFFFFF, 32'hFFFFFFFE, 32'hFFFFFFFF);
        4: apply_config(32'd1, 32'd999, 32'd1001);
        default: begin
          mn = $urandom_range(0, 50000);
          apply_config($urandom_range(0, 200), mn, mn + $urandom_range(0, 100000));
        end
      endcase
      if (ph < 2) begin
        send_idle_pct = 27;
        recv_idle_pct = 80;
      end else if (ph < 4) begin
        send_idle_pct = 80;
        recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_item(CMD_STREAM_ON, $urandom, $urandom);
      repeat (PHASE_ITEMS) send_random();
      wait_idle();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("PASS index_pulse_angle_estimator");
    end else begin
      $display("FAIL index_pulse_angle_estimator");
    end
    $finish;
  end

endmodule
